>>> src/sds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types and constants for the SCAN disk scheduler.
// ----------------------------------------------------------------------------
package sds_pkg;

    localparam int MAX_REQUESTS = 32;

    localparam int CYL_W       = 16;
    localparam int SEEK_W      = 17;
    localparam int CYL_CNT_W   = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HEAD = 2'd0,
        CFG_CYL_COUNT  = 2'd1,
        CFG_SWEEP_UP   = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SPL_RD,
        ST_SPL_CMP,
        ST_A_RD,
        ST_A_MV,
        ST_END_MV,
        ST_B_RD,
        ST_B_MV
    } t_state;

    typedef enum logic [1:0] {
        ADDR_IDX,
        ADDR_IDX_M1,
        ADDR_IDX_M2,
        ADDR_IDX_P1
    } t_addr_sel;

    typedef struct packed {
        logic      load;
        logic      ins_shift;
        logic      ins_place;
        logic      svc_start;
        logic      idx_inc;
        logic      idx_dec;
        logic      split_take;
        logic      idx_from_split;
        logic      move;
        logic      move_end;
        logic      final_visit;
        logic      clear_count;
        t_addr_sel addr_sel;
    } t_cmd;

    typedef struct packed {
        logic idx_zero;
        logic idx_one;
        logic idx_eq_cnt;
        logic idx_p1_eq_cnt;
        logic split_zero;
        logic split_eq_cnt;
        logic full;
        logic end_flag;
        logic gt_req;
        logic ge_head;
        logic up;
        logic out_busy;
    } t_stat;

endpackage

>>> src/sds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_ctrl
// Sequencer for insertion, split search and the two sweep phases.
// ----------------------------------------------------------------------------
module sds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sds_pkg::t_stat i_stat,
    output sds_pkg::t_cmd  o_cmd
);

    sds_pkg::t_state r_state;
    sds_pkg::t_state n_state;
    logic            w_asc;
    logic            w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.addr_sel = sds_pkg::ADDR_IDX;
        o_in_ready = 1'b0;
        w_asc  = (r_state == sds_pkg::ST_A_RD || r_state == sds_pkg::ST_A_MV) ?
                 i_stat.up : !i_stat.up;
        w_done = w_asc ? i_stat.idx_eq_cnt : i_stat.idx_zero;
        unique case (r_state)
            sds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sds_pkg::ST_INS_RD;
                end
            end
            sds_pkg::ST_INS_RD, sds_pkg::ST_INS_CMP: begin
                o_cmd.addr_sel = (r_state == sds_pkg::ST_INS_RD) ?
                                 sds_pkg::ADDR_IDX_M1 : sds_pkg::ADDR_IDX_M2;
                if (r_state == sds_pkg::ST_INS_CMP && i_stat.gt_req) begin
                    o_cmd.ins_shift = 1'b1;
                    if (i_stat.idx_one) begin
                        n_state = sds_pkg::ST_INS_RD;
                    end
                end else if (r_state == sds_pkg::ST_INS_RD && !i_stat.full &&
                             !i_stat.idx_zero) begin
                    n_state = sds_pkg::ST_INS_CMP;
                end else begin
                    o_cmd.ins_place = !i_stat.full;
                    if (i_stat.end_flag) begin
                        o_cmd.svc_start = 1'b1;
                        n_state         = sds_pkg::ST_SPL_RD;
                    end else begin
                        n_state = sds_pkg::ST_IDLE;
                    end
                end
            end
            sds_pkg::ST_SPL_RD: begin
                if (i_stat.idx_eq_cnt) begin
                    o_cmd.split_take = 1'b1;
                    n_state          = sds_pkg::ST_A_RD;
                end else begin
                    n_state = sds_pkg::ST_SPL_CMP;
                end
            end
            sds_pkg::ST_SPL_CMP: begin
                o_cmd.addr_sel = sds_pkg::ADDR_IDX_P1;
                if (i_stat.ge_head) begin
                    o_cmd.split_take = 1'b1;
                    n_state          = sds_pkg::ST_A_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    if (i_stat.idx_p1_eq_cnt) begin
                        o_cmd.split_take = 1'b1;
                        n_state          = sds_pkg::ST_A_RD;
                    end
                end
            end
            sds_pkg::ST_A_RD, sds_pkg::ST_B_RD: begin
                o_cmd.addr_sel = w_asc ? sds_pkg::ADDR_IDX : sds_pkg::ADDR_IDX_M1;
                if (!w_done) begin
                    n_state = (r_state == sds_pkg::ST_A_RD) ?
                              sds_pkg::ST_A_MV : sds_pkg::ST_B_MV;
                end else if (r_state == sds_pkg::ST_A_RD) begin
                    n_state = sds_pkg::ST_END_MV;
                end else begin
                    o_cmd.clear_count = 1'b1;
                    n_state           = sds_pkg::ST_IDLE;
                end
            end
            sds_pkg::ST_A_MV, sds_pkg::ST_B_MV: begin
                o_cmd.addr_sel = w_asc ? sds_pkg::ADDR_IDX : sds_pkg::ADDR_IDX_M1;
                if (!i_stat.out_busy) begin
                    o_cmd.move    = 1'b1;
                    o_cmd.idx_inc = w_asc;
                    o_cmd.idx_dec = !w_asc;
                    if (r_state == sds_pkg::ST_B_MV) begin
                        o_cmd.final_visit = w_asc ? i_stat.idx_p1_eq_cnt :
                                                    i_stat.idx_one;
                    end
                    if (o_cmd.final_visit) begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = sds_pkg::ST_IDLE;
                    end else begin
                        n_state = (r_state == sds_pkg::ST_A_MV) ?
                                  sds_pkg::ST_A_RD : sds_pkg::ST_B_RD;
                    end
                end
            end
            sds_pkg::ST_END_MV: begin
                if (!i_stat.out_busy) begin
                    o_cmd.move           = 1'b1;
                    o_cmd.move_end       = 1'b1;
                    o_cmd.idx_from_split = 1'b1;
                    o_cmd.final_visit    = i_stat.up ? i_stat.split_zero :
                                                       i_stat.split_eq_cnt;
                    if (o_cmd.final_visit) begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = sds_pkg::ST_IDLE;
                    end else begin
                        n_state = sds_pkg::ST_B_RD;
                    end
                end
            end
            default: begin
                n_state = sds_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/sds_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_dpath
// Request store, index and split registers, head tracking and result register.
// ----------------------------------------------------------------------------
module sds_dpath #(
    parameter int MaxRequests = sds_pkg::MAX_REQUESTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sds_pkg::t_cmd                     i_cmd,
    output sds_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [sds_pkg::CYL_W-1:0]         i_req,
    input  logic                              i_batch_end,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [sds_pkg::OUT_TDATA_W-1:0]   o_out_tdata,
    output logic                              o_out_last
);

    localparam int IW = $clog2(MaxRequests + 1);
    localparam int AW = (MaxRequests > 1) ? $clog2(MaxRequests) : 1;
    localparam int PadW = sds_pkg::OUT_TDATA_W - sds_pkg::CYL_W - sds_pkg::SEEK_W;

    logic [sds_pkg::CYL_W-1:0]     r_store [MaxRequests];
    logic [sds_pkg::CYL_W-1:0]     r_rd_data;
    logic [sds_pkg::CYL_W-1:0]     r_start_head;
    logic [sds_pkg::CYL_CNT_W-1:0] r_cyl_count;
    logic                          r_sweep_up;
    logic [IW-1:0]                 r_count;
    logic [IW-1:0]                 r_idx;
    logic [IW-1:0]                 r_split;
    logic [sds_pkg::CYL_W-1:0]     r_req;
    logic                          r_end;
    logic [sds_pkg::CYL_W-1:0]     r_head;
    logic [sds_pkg::SEEK_W-1:0]    r_sum;
    logic                          r_out_valid;
    logic [sds_pkg::CYL_W-1:0]     r_visit;
    logic [sds_pkg::SEEK_W-1:0]    r_seek;
    logic                          r_final;

    logic [sds_pkg::CYL_W-1:0]     w_last;
    logic [sds_pkg::CYL_W-1:0]     w_req_sat;
    logic [sds_pkg::CYL_W-1:0]     w_start_sat;
    logic [IW:0]                   w_idx_p1;
    logic [IW-1:0]                 w_rd_idx;
    logic [sds_pkg::CYL_W-1:0]     w_cyl;
    logic [sds_pkg::CYL_W-1:0]     w_delta;
    logic [sds_pkg::SEEK_W-1:0]    n_sum;

    always_comb begin
        if (r_cyl_count == '0) begin
            w_last = '0;
        end else if (r_cyl_count[sds_pkg::CYL_CNT_W-1]) begin
            w_last = '1;
        end else begin
            w_last = r_cyl_count[sds_pkg::CYL_W-1:0] - 1'b1;
        end
    end

    assign w_req_sat   = (i_req > w_last) ? w_last : i_req;
    assign w_start_sat = (r_start_head > w_last) ? w_last : r_start_head;
    assign w_idx_p1    = {1'b0, r_idx} + 1'b1;

    always_comb begin
        unique case (i_cmd.addr_sel)
            sds_pkg::ADDR_IDX:    w_rd_idx = r_idx;
            sds_pkg::ADDR_IDX_M1: w_rd_idx = r_idx - 1'b1;
            sds_pkg::ADDR_IDX_M2: w_rd_idx = r_idx - 2'd2;
            sds_pkg::ADDR_IDX_P1: w_rd_idx = w_idx_p1[IW-1:0];
            default:              w_rd_idx = r_idx;
        endcase
    end

    always_comb begin
        if (!i_cmd.move_end) begin
            w_cyl = r_rd_data;
        end else if (r_sweep_up) begin
            w_cyl = w_last;
        end else begin
            w_cyl = '0;
        end
        w_delta = (w_cyl >= r_head) ? (w_cyl - r_head) : (r_head - w_cyl);
        n_sum   = r_sum + {1'b0, w_delta};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_shift) begin
            r_store[r_idx[AW-1:0]] <= r_rd_data;
        end else if (i_cmd.ins_place) begin
            r_store[r_idx[AW-1:0]] <= r_req;
        end
        r_rd_data <= r_store[w_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= '0;
            r_cyl_count  <= sds_pkg::CYL_CNT_W'(65536);
            r_sweep_up   <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (sds_pkg::t_cfg_idx'(i_cfg_idx))
                    sds_pkg::CFG_START_HEAD:
                        r_start_head <= i_cfg_data[sds_pkg::CYL_W-1:0];
                    sds_pkg::CFG_CYL_COUNT: r_cyl_count <= i_cfg_data;
                    sds_pkg::CFG_SWEEP_UP:  r_sweep_up <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.ins_place) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= w_req_sat;
            r_end <= i_batch_end;
            r_idx <= r_count;
        end else if (i_cmd.svc_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_from_split) begin
            r_idx <= r_split;
        end else if (i_cmd.ins_shift || i_cmd.idx_dec) begin
            r_idx <= r_idx - 1'b1;
        end else if (i_cmd.idx_inc) begin
            r_idx <= w_idx_p1[IW-1:0];
        end
        if (i_cmd.split_take) begin
            r_split <= i_cmd.idx_inc ? w_idx_p1[IW-1:0] : r_idx;
        end
        if (i_cmd.svc_start) begin
            r_head <= w_start_sat;
            r_sum  <= '0;
        end else if (i_cmd.move) begin
            r_head <= w_cyl;
            r_sum  <= n_sum;
        end
        if (i_cmd.move) begin
            r_visit <= w_cyl;
            r_seek  <= n_sum;
            r_final <= i_cmd.final_visit;
        end
    end

    assign o_stat.idx_zero      = (r_idx == '0);
    assign o_stat.idx_one       = (r_idx == IW'(1));
    assign o_stat.idx_eq_cnt    = (r_idx == r_count);
    assign o_stat.idx_p1_eq_cnt = (w_idx_p1 == {1'b0, r_count});
    assign o_stat.split_zero    = (r_split == '0);
    assign o_stat.split_eq_cnt  = (r_split == r_count);
    assign o_stat.full          = (r_count == IW'(MaxRequests));
    assign o_stat.end_flag      = r_end;
    assign o_stat.gt_req        = (r_rd_data > r_req);
    assign o_stat.ge_head       = (r_rd_data >= r_head);
    assign o_stat.up            = r_sweep_up;
    assign o_stat.out_busy      = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {{PadW{1'b0}}, r_seek, r_visit};
    assign o_out_last  = r_final;

endmodule

>>> src/scan_disk_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scan_disk_scheduler
// Collects a sorted batch of cylinder requests and serves it in SCAN order.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Contents
// s_axis    in         s_axis_tvalid/tready   request cylinder, tlast = batch end
// m_axis    out        m_axis_tvalid/tready   visit cylinder and seek total,
//                                             tlast = final visit
// cfg       in         i_cfg_we               register index and write data
//
// A request into an empty or a full store needs no compare; otherwise it is
// compared and shifted past each larger stored entry in the request memory,
// whose single write port moves one entry per cycle.
// On a batch end, the split search reads one entry per cycle, and each request
// visit then passes a memory read state and a move state that waits on a stall.
// Reset clears the request count and the result valid flag; the store is not cleared.
// A stalled result holds the sweep; a new request is taken once the last visit
// is in the result register.
// ----------------------------------------------------------------------------
module scan_disk_scheduler #(
    parameter int MaxRequests = sds_pkg::MAX_REQUESTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] request_cylinder
    input  logic [sds_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] visit_cylinder, [32:16] seek_total, [39:33] zero
    output logic [sds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [sds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sds_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sds_pkg::t_cmd  w_cmd;
    sds_pkg::t_stat w_stat;

    sds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sds_dpath #(
        .MaxRequests (MaxRequests)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (s_axis_tdata[sds_pkg::CYL_W-1:0]),
        .i_batch_end (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

>>> src/sds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks for the SCAN disk scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sds_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sds_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled result transfer changed.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result presented right after reset.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Request taken while the previous one is still being stored.");

    a_result_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("Result appeared while the block was idle.");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the SCAN disk scheduler. Request batches are
// streamed in and each batch is predicted as an elevator sweep from the
// configured head. Every visit is compared with the predicted cylinder,
// seek total and final flag. Register values, extremes and store overflow
// are covered while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [sds_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_REQUESTS = 260;

    typedef struct {
        bit [sds_pkg::CYL_W-1:0]  cylinder;
        bit [sds_pkg::SEEK_W-1:0] seek;
        bit                       is_end;
    } t_visit;

    class t_sweep_tracker;
        bit [sds_pkg::CYL_W-1:0]     start_head = '0;
        bit [sds_pkg::CYL_CNT_W-1:0] cylinder_count = 17'd65536;
        bit                          sweep_up = 1'b1;
        bit [sds_pkg::CYL_W-1:0]     sorted_requests[$];
        bit [sds_pkg::CYL_W-1:0]     head;
        bit [sds_pkg::SEEK_W-1:0]    travel;
        t_visit                      expected_visits[$];
        int                          mismatches = 0;
        int                          requests = 0;
        int                          batches = 0;
        int                          visits = 0;

        function void set_register(logic [sds_pkg::CFG_IDX_W-1:0] idx,
                                   logic [sds_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sds_pkg::CFG_START_HEAD: start_head = data[sds_pkg::CYL_W-1:0];
                sds_pkg::CFG_CYL_COUNT:  cylinder_count = data[sds_pkg::CYL_CNT_W-1:0];
                sds_pkg::CFG_SWEEP_UP:   sweep_up = data[0];
                default: ;
            endcase
        endfunction

        function void move_head(bit [sds_pkg::CYL_W-1:0] cyl, bit is_end);
            t_visit v;
            bit [sds_pkg::SEEK_W-1:0] delta;
            delta = (cyl >= head) ? sds_pkg::SEEK_W'(cyl - head) :
                                    sds_pkg::SEEK_W'(head - cyl);
            travel = travel + delta;
            head = cyl;
            v.cylinder = cyl;
            v.seek = travel;
            v.is_end = is_end;
            expected_visits.push_back(v);
        endfunction

        function void take_request(logic [sds_pkg::CYL_W-1:0] cyl, logic batch_end);
            bit [sds_pkg::CYL_W-1:0] last_cyl;
            bit [sds_pkg::CYL_W-1:0] req;
            int pos;
            int n;
            int split;
            int i;
            if (cylinder_count == 0) begin
                last_cyl = '0;
            end else if (cylinder_count > 17'd65536) begin
                last_cyl = 16'hFFFF;
            end else begin
                last_cyl = sds_pkg::CYL_W'(cylinder_count - 1);
            end
            req = (cyl > last_cyl) ? last_cyl : cyl;
            requests++;
            if (sorted_requests.size() < sds_pkg::MAX_REQUESTS) begin
                pos = 0;
                while (pos < sorted_requests.size() && sorted_requests[pos] <= req) pos++;
                sorted_requests.insert(pos, req);
            end
            if (!batch_end) return;
            batches++;
            n = sorted_requests.size();
            head = (start_head > last_cyl) ? last_cyl : start_head;
            travel = '0;
            split = n;
            for (i = 0; i < n; i++) begin
                if (sorted_requests[i] >= head) begin
                    split = i;
                    break;
                end
            end
            if (sweep_up) begin
                for (i = split; i < n; i++) move_head(sorted_requests[i], 1'b0);
                move_head(last_cyl, split == 0);
                for (i = split; i > 0; i--) move_head(sorted_requests[i-1], i == 1);
            end else begin
                for (i = split; i > 0; i--) move_head(sorted_requests[i-1], 1'b0);
                move_head('0, split == n);
                for (i = split; i < n; i++) move_head(sorted_requests[i], i + 1 == n);
            end
            sorted_requests.delete();
        endfunction

        function void check_visit(logic [sds_pkg::OUT_TDATA_W-1:0] data, logic tlast);
            t_visit v;
            if (expected_visits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected visit: cyl %0d seek %0d last %0b",
                             data[15:0], data[32:16], tlast);
                end
                return;
            end
            v = expected_visits.pop_front();
            visits++;
            if (data[15:0] !== v.cylinder || data[32:16] !== v.seek ||
                tlast !== v.is_end || data[39:33] !== '0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Visit mismatch: expected cyl %0d seek %0d last %0b,",
                             v.cylinder, v.seek, v.is_end);
                    $display("    got cyl %0d seek %0d last %0b pad %0h",
                             data[15:0], data[32:16], tlast, data[39:33]);
                end
            end
        endfunction

        function int pending();
            return expected_visits.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sds_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sds_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            i_cfg_we = 1'b0;
    logic [sds_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [sds_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_sweep_tracker sb = new();
    bit idling_on = 1'b1;
    int rx_stall = 0;
    int random_items = 0;
    int settings_used = 1;

    scan_disk_scheduler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.take_request(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) sb.check_visit(m_axis_tdata, m_axis_tlast);
        end
    end

    always @(negedge i_clk) begin
        if (rx_stall != 0) begin
            rx_stall--;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rx_stall = $urandom_range(1, 15);
        end
        m_axis_tready <= (rx_stall == 0);
    end

    task automatic push_request(input logic [sds_pkg::CYL_W-1:0] cyl, input logic batch_end);
        int gap;
        gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cyl;
        s_axis_tlast  <= batch_end;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_batch(input int cyls[$]);
        int k;
        for (k = 0; k < cyls.size(); k++) begin
            push_request(cyls[k][sds_pkg::CYL_W-1:0], k == cyls.size() - 1);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sds_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(idx, data);
    endtask

    task automatic random_phase(input int phase);
        int start;
        int count;
        int last_cyl;
        int size;
        int b;
        int k;
        int cyls[$];
        case ($urandom_range(0, 3))
            0:       start = 0;
            1:       start = 65535;
            default: start = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 9))
            0:       count = 1;
            1:       count = 2;
            2:       count = 0;
            3:       count = $urandom_range(65537, 131071);
            4, 5:    count = $urandom_range(1, 65536);
            default: count = 65536;
        endcase
        last_cyl = (count == 0) ? 0 : (count > 65536) ? 65535 : count - 1;
        write_reg(sds_pkg::CFG_START_HEAD, sds_pkg::CFG_DATA_W'(start));
        write_reg(sds_pkg::CFG_CYL_COUNT, sds_pkg::CFG_DATA_W'(count));
        write_reg(sds_pkg::CFG_SWEEP_UP, sds_pkg::CFG_DATA_W'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_SPARE, sds_pkg::CFG_DATA_W'($urandom_range(0, 131071)));
        end
        settings_used++;
        for (b = 0; b < 3; b++) begin
            case ($urandom_range(0, 19))
                0:          size = $urandom_range(33, 36);
                1, 2, 3:    size = $urandom_range(9, 32);
                default:    size = $urandom_range(1, 8);
            endcase
            if (phase == 0 && b == 0) size = 34;
            cyls.delete();
            for (k = 0; k < size; k++) begin
                case ($urandom_range(0, 15))
                    0, 1:    cyls.push_back($urandom_range(0, 65535));
                    2:       cyls.push_back(last_cyl);
                    3:       cyls.push_back(0);
                    default: cyls.push_back($urandom_range(0, last_cyl));
                endcase
            end
            send_batch(cyls);
            random_items += size;
        end
        drain();
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_batch('{65535, 0, 32768});
        send_batch('{0});
        drain();

        write_reg(sds_pkg::CFG_START_HEAD, 17'd40000);
        write_reg(sds_pkg::CFG_CYL_COUNT, 17'd50000);
        write_reg(sds_pkg::CFG_SWEEP_UP, 17'd0);
        send_batch('{60000, 100, 45000, 39999});
        send_batch('{10, 20});
        drain();

        write_reg(sds_pkg::CFG_START_HEAD, 17'd65535);
        write_reg(sds_pkg::CFG_CYL_COUNT, 17'd1000);
        write_reg(sds_pkg::CFG_SWEEP_UP, 17'd1);
        send_batch('{5, 500});
        drain();

        write_reg(sds_pkg::CFG_CYL_COUNT, 17'd0);
        write_reg(sds_pkg::CFG_SWEEP_UP, 17'd0);
        write_reg(sds_pkg::CFG_START_HEAD, 17'd123);
        send_batch('{7, 0, 65535});
        drain();

        write_reg(sds_pkg::CFG_CYL_COUNT, 17'd131071);
        write_reg(sds_pkg::CFG_START_HEAD, 17'd65535);
        write_reg(CFG_IDX_SPARE, 17'd131071);
        send_batch('{65535, 1, 32767});
        drain();
        settings_used += 4;

        phase = 0;
        while (random_items < RANDOM_REQUESTS) begin
            idling_on = (random_items < RANDOM_REQUESTS - 50) && (phase % 4 != 3);
            random_phase(phase);
            phase++;
        end

        $display("Run covered %0d requests in %0d batches under %0d register settings.",
                 sb.requests, sb.batches, settings_used);
        $display("%0d visits were checked, %0d mismatches found.", sb.visits, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d visits outstanding.", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
